@@ rtl/wtve_pkg.sv @@
// Shared types and constants for the windowed track velocity estimator.
`timescale 1ns / 1ps

package wtve_pkg;

    localparam int POS_W  = 32;
    localparam int SEC_W  = 32;
    localparam int USEC_W = 20;
    localparam int T_W    = 52;
    localparam int VEL_W  = 32;
    localparam int SHF_W  = 33;
    localparam int ICNT_W = 4;
    localparam int CFG_W  = 5;
    localparam int DIV_W  = 53;

    localparam logic [USEC_W-1:0] USEC_PER_SEC  = 20'd1000000;
    localparam logic [CFG_W-1:0]  WINDOW_RESET  = 5'd8;

    // Command strobes from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic rd_prev;
        logic wr_sample;
        logic rd_old;
        logic mul;
        logic div_start;
        logic acc;
        logic mean_start;
        logic out_load;
    } t_cmd;

    // Status from the datapath back to the controller.
    typedef struct packed {
        logic has_int;
        logic dt_pos;
        logic div_done;
    } t_sts;

endpackage

@@ rtl/wtve_ram.sv @@
// Generic single write port, single read port RAM with registered read data.
`timescale 1ns / 1ps

module wtve_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/wtve_div.sv @@
// Unsigned restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module wtve_div #(
    parameter int DW = 53,
    parameter int SHORT_W = 37
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic          i_short,
    input  logic [DW-1:0] i_dividend,
    input  logic [DW-1:0] i_divisor,
    output logic          o_done,
    output logic [DW-1:0] o_quotient
);

    localparam int CNTW = $clog2(DW + 1);

    logic [DW-1:0]   r_rem;
    logic [DW-1:0]   r_quo;
    logic [DW-1:0]   r_den;
    logic [CNTW-1:0] r_cnt;
    logic            r_busy;
    logic            r_done;

    logic [DW:0]     shifted;
    logic [DW:0]     diff;
    logic            ge;

    always_comb begin
        shifted = {r_rem, r_quo[DW-1]};
        diff    = shifted - {1'b0, r_den};
        ge      = (shifted >= {1'b0, r_den});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_short ? CNTW'(SHORT_W) : CNTW'(DW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNTW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // A short dividend is left aligned so the loop can stop early.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_den <= i_divisor;
            r_quo <= i_short ? (i_dividend << (DW - SHORT_W)) : i_dividend;
        end else if (r_busy) begin
            r_rem <= ge ? diff[DW-1:0] : shifted[DW-1:0];
            r_quo <= {r_quo[DW-2:0], ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

@@ rtl/wtve_dp.sv @@
// Datapath: sample and interval stores, running sums, dividers and result register.
`timescale 1ns / 1ps

module wtve_dp #(
    parameter int MAX_WINDOW = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  wtve_pkg::t_cmd                i_cmd,
    output wtve_pkg::t_sts                o_sts,
    input  logic                          i_cfg_we,
    input  logic [wtve_pkg::CFG_W-1:0]    i_cfg_data,
    input  logic signed [wtve_pkg::POS_W-1:0] i_pos_x,
    input  logic signed [wtve_pkg::POS_W-1:0] i_pos_y,
    input  logic [wtve_pkg::SEC_W-1:0]    i_time_sec,
    input  logic [wtve_pkg::USEC_W-1:0]   i_time_usec,
    output logic signed [wtve_pkg::SHF_W-1:0] o_shift_x,
    output logic signed [wtve_pkg::SHF_W-1:0] o_shift_y,
    output logic signed [wtve_pkg::VEL_W-1:0] o_vel_x,
    output logic signed [wtve_pkg::VEL_W-1:0] o_vel_y,
    output logic [wtve_pkg::ICNT_W-1:0]   o_interval_count,
    output logic                          o_bad_interval
);

    import wtve_pkg::*;

    localparam int AW    = $clog2(MAX_WINDOW);
    localparam int CW    = $clog2(MAX_WINDOW + 1);
    localparam int SSW   = CW + 1;
    localparam int LW    = (CW > CFG_W) ? CW : CFG_W;
    localparam int SUM_W = VEL_W + AW + 1;
    localparam int SMP_W = 2 * POS_W + T_W;
    localparam int INT_W = 2 * VEL_W + 1;

    localparam logic [DIV_W-1:0] POS_LIM = DIV_W'(64'h7FFF_FFFF);
    localparam logic [DIV_W-1:0] NEG_LIM = DIV_W'(64'h8000_0000);

    function automatic logic signed [VEL_W-1:0] sat_vel(input logic [DIV_W-1:0] mag,
                                                        input logic neg);
        logic signed [VEL_W-1:0] res;
        if (neg) begin
            res = (mag > NEG_LIM) ? $signed(32'h8000_0000) : -$signed(mag[VEL_W-1:0]);
        end else begin
            res = (mag > POS_LIM) ? $signed(32'h7FFF_FFFF) : $signed(mag[VEL_W-1:0]);
        end
        return res;
    endfunction

    // Window state.
    logic [CFG_W-1:0] r_ws;
    logic [CW-1:0]    r_count;
    logic [AW-1:0]    r_head;
    logic signed [SUM_W-1:0] r_sum_x;
    logic signed [SUM_W-1:0] r_sum_y;
    logic [CW-1:0]    r_bad_cnt;

    // Per item working registers.
    logic signed [POS_W-1:0] r_x_new, r_y_new, r_prev_x, r_prev_y;
    logic [SEC_W-1:0]  r_sec;
    logic [USEC_W-1:0] r_usec;
    logic [T_W-1:0]    r_t_new, r_prev_t;
    logic [AW-1:0]     r_slot;
    logic              r_full;
    logic signed [SHF_W-1:0] r_dx, r_dy, r_shift_x, r_shift_y;
    logic signed [T_W:0]     r_dt;
    logic [DIV_W-1:0]  r_num_x, r_num_y;
    logic signed [VEL_W-1:0] r_drop_vx, r_drop_vy;
    logic              r_drop_bad;

    // Result register.
    logic signed [SHF_W-1:0] r_o_shift_x, r_o_shift_y;
    logic signed [VEL_W-1:0] r_o_vel_x, r_o_vel_y;
    logic [ICNT_W-1:0] r_o_icnt;
    logic              r_o_bad;

    logic [LW-1:0]  ws_ext, limit_ext, n_ext;
    logic [CW-1:0]  limit;
    logic [SSW-1:0] slot_sum;
    logic [AW-1:0]  slot_calc, prev_addr, head_inc;
    logic           has_int, dt_pos;

    logic [SMP_W-1:0] smp_rdata, smp_wdata;
    logic [AW-1:0]    smp_raddr;
    logic [INT_W-1:0] int_rdata, int_wdata;
    logic [AW-1:0]    int_raddr;

    logic [SHF_W-1:0] mag_dx, mag_dy;
    logic [SUM_W-1:0] mag_sx, mag_sy;
    logic             div_short;
    logic [DIV_W-1:0] dvd_x, dvd_y, dvs;
    logic             done_x, done_y;
    logic [DIV_W-1:0] q_x, q_y;
    logic signed [VEL_W-1:0] vel_x_new, vel_y_new;

    always_comb begin
        ws_ext = LW'(r_ws);
        if (ws_ext == '0) begin
            limit_ext = LW'(1);
        end else if (ws_ext > LW'(MAX_WINDOW)) begin
            limit_ext = LW'(MAX_WINDOW);
        end else begin
            limit_ext = ws_ext;
        end
        limit = CW'(limit_ext);

        slot_sum  = SSW'(r_head) + SSW'(r_count);
        slot_calc = (slot_sum >= SSW'(MAX_WINDOW)) ? AW'(slot_sum - SSW'(MAX_WINDOW))
                                                   : AW'(slot_sum);
        prev_addr = (r_slot == '0) ? AW'(MAX_WINDOW - 1) : r_slot - 1'b1;
        head_inc  = (r_head == AW'(MAX_WINDOW - 1)) ? '0 : r_head + 1'b1;

        has_int = (r_count >= CW'(2));
        n_ext   = has_int ? LW'(r_count - 1'b1) : '0;
        dt_pos  = !r_dt[T_W] && (r_dt != '0);

        mag_dx = r_dx[SHF_W-1] ? SHF_W'(-r_dx) : SHF_W'(r_dx);
        mag_dy = r_dy[SHF_W-1] ? SHF_W'(-r_dy) : SHF_W'(r_dy);
        mag_sx = r_sum_x[SUM_W-1] ? SUM_W'(-r_sum_x) : SUM_W'(r_sum_x);
        mag_sy = r_sum_y[SUM_W-1] ? SUM_W'(-r_sum_y) : SUM_W'(r_sum_y);

        div_short = i_cmd.mean_start;
        dvd_x = i_cmd.mean_start ? DIV_W'(mag_sx) : r_num_x;
        dvd_y = i_cmd.mean_start ? DIV_W'(mag_sy) : r_num_y;
        dvs   = i_cmd.mean_start ? DIV_W'(n_ext) : DIV_W'(r_dt[T_W-1:0]);

        vel_x_new = dt_pos ? sat_vel(q_x, r_dx[SHF_W-1]) : '0;
        vel_y_new = dt_pos ? sat_vel(q_y, r_dy[SHF_W-1]) : '0;

        smp_raddr = i_cmd.rd_prev ? prev_addr : r_head;
        smp_wdata = {r_x_new, r_y_new, r_t_new};
        int_raddr = r_head;
        int_wdata = {vel_x_new, vel_y_new, !dt_pos};
    end

    assign o_sts.has_int  = has_int;
    assign o_sts.dt_pos   = dt_pos;
    assign o_sts.div_done = done_x & done_y;

    wtve_ram #(.WIDTH(SMP_W), .DEPTH(MAX_WINDOW)) u_smp_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr_sample),
        .i_waddr (r_slot),
        .i_wdata (smp_wdata),
        .i_raddr (smp_raddr),
        .o_rdata (smp_rdata)
    );

    wtve_ram #(.WIDTH(INT_W), .DEPTH(MAX_WINDOW)) u_int_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.acc),
        .i_waddr (r_slot),
        .i_wdata (int_wdata),
        .i_raddr (int_raddr),
        .o_rdata (int_rdata)
    );

    wtve_div #(.DW(DIV_W), .SHORT_W(SUM_W)) u_div_x (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start | i_cmd.mean_start),
        .i_short    (div_short),
        .i_dividend (dvd_x),
        .i_divisor  (dvs),
        .o_done     (done_x),
        .o_quotient (q_x)
    );

    wtve_div #(.DW(DIV_W), .SHORT_W(SUM_W)) u_div_y (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start | i_cmd.mean_start),
        .i_short    (div_short),
        .i_dividend (dvd_y),
        .i_divisor  (dvs),
        .o_done     (done_y),
        .o_quotient (q_y)
    );

    // Window control state: window size, count, head, running sums and bad interval count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ws      <= WINDOW_RESET;
            r_count   <= '0;
            r_head    <= '0;
            r_sum_x   <= '0;
            r_sum_y   <= '0;
            r_bad_cnt <= '0;
        end else if (i_cfg_we) begin
            r_ws      <= i_cfg_data;
            r_count   <= '0;
            r_head    <= '0;
            r_sum_x   <= '0;
            r_sum_y   <= '0;
            r_bad_cnt <= '0;
        end else begin
            if (i_cmd.wr_sample) begin
                if (r_full) begin
                    r_head <= head_inc;
                end else begin
                    r_count <= r_count + 1'b1;
                end
            end
            // The new interval enters the sums and, on a full window, the
            // interval ending at the new oldest sample leaves them.
            if (i_cmd.acc) begin
                r_sum_x <= r_sum_x + SUM_W'(vel_x_new)
                         - (r_full ? SUM_W'(r_drop_vx) : SUM_W'(0));
                r_sum_y <= r_sum_y + SUM_W'(vel_y_new)
                         - (r_full ? SUM_W'(r_drop_vy) : SUM_W'(0));
                r_bad_cnt <= r_bad_cnt + CW'(!dt_pos)
                           - ((r_full && r_drop_bad) ? CW'(1) : CW'(0));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x_new <= i_pos_x;
            r_y_new <= i_pos_y;
            r_sec   <= i_time_sec;
            r_usec  <= i_time_usec;
            r_slot  <= slot_calc;
            r_full  <= (r_count == limit);
        end
        if (i_cmd.rd_prev) begin
            r_t_new <= T_W'(r_sec) * T_W'(USEC_PER_SEC) + T_W'(r_usec);
        end
        if (i_cmd.wr_sample) begin
            r_prev_x <= $signed(smp_rdata[SMP_W-1 -: POS_W]);
            r_prev_y <= $signed(smp_rdata[T_W +: POS_W]);
            r_prev_t <= smp_rdata[T_W-1:0];
        end
        if (i_cmd.rd_old) begin
            r_dx <= $signed({r_x_new[POS_W-1], r_x_new}) - $signed({r_prev_x[POS_W-1], r_prev_x});
            r_dy <= $signed({r_y_new[POS_W-1], r_y_new}) - $signed({r_prev_y[POS_W-1], r_prev_y});
            r_dt <= $signed({1'b0, r_t_new}) - $signed({1'b0, r_prev_t});
        end
        // Both stores were read at the head, after it advanced if the window was full.
        if (i_cmd.mul) begin
            r_drop_vx  <= $signed(int_rdata[INT_W-1 -: VEL_W]);
            r_drop_vy  <= $signed(int_rdata[1 +: VEL_W]);
            r_drop_bad <= int_rdata[0];
            r_shift_x <= $signed({r_x_new[POS_W-1], r_x_new})
                       - $signed({smp_rdata[SMP_W-1], smp_rdata[SMP_W-1 -: POS_W]});
            r_shift_y <= $signed({r_y_new[POS_W-1], r_y_new})
                       - $signed({smp_rdata[T_W+POS_W-1], smp_rdata[T_W +: POS_W]});
            r_num_x <= mag_dx * USEC_PER_SEC;
            r_num_y <= mag_dy * USEC_PER_SEC;
        end
        if (i_cmd.out_load) begin
            if (has_int) begin
                r_o_shift_x <= r_shift_x;
                r_o_shift_y <= r_shift_y;
                r_o_vel_x   <= sat_vel(q_x, r_sum_x[SUM_W-1]);
                r_o_vel_y   <= sat_vel(q_y, r_sum_y[SUM_W-1]);
                r_o_icnt    <= n_ext[ICNT_W-1:0];
                r_o_bad     <= (r_bad_cnt != '0);
            end else begin
                r_o_shift_x <= '0;
                r_o_shift_y <= '0;
                r_o_vel_x   <= '0;
                r_o_vel_y   <= '0;
                r_o_icnt    <= '0;
                r_o_bad     <= 1'b0;
            end
        end
    end

    assign o_shift_x        = r_o_shift_x;
    assign o_shift_y        = r_o_shift_y;
    assign o_vel_x          = r_o_vel_x;
    assign o_vel_y          = r_o_vel_y;
    assign o_interval_count = r_o_icnt;
    assign o_bad_interval   = r_o_bad;

endmodule

@@ rtl/wtve_ctrl.sv @@
// Controller state machine: sequences one sample through the datapath.
`timescale 1ns / 1ps

module wtve_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    output logic           o_valid,
    input  logic           i_ready,
    output wtve_pkg::t_cmd o_cmd,
    input  wtve_pkg::t_sts i_sts
);

    import wtve_pkg::*;

    typedef enum logic [10:0] {
        S_IDLE  = 11'b000_0000_0001,
        S_TIME  = 11'b000_0000_0010,
        S_WRITE = 11'b000_0000_0100,
        S_OLD   = 11'b000_0000_1000,
        S_MUL   = 11'b000_0001_0000,
        S_VDIV  = 11'b000_0010_0000,
        S_VWAIT = 11'b000_0100_0000,
        S_ACC   = 11'b000_1000_0000,
        S_MDIV  = 11'b001_0000_0000,
        S_MWAIT = 11'b010_0000_0000,
        S_FIN   = 11'b100_0000_0000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        out_free    = !r_out_valid || i_ready;
        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_TIME;
                end
            end
            S_TIME: begin
                o_cmd.rd_prev = 1'b1;
                n_state       = S_WRITE;
            end
            S_WRITE: begin
                o_cmd.wr_sample = 1'b1;
                n_state         = S_OLD;
            end
            S_OLD: begin
                o_cmd.rd_old = 1'b1;
                n_state      = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                priority if (!i_sts.has_int) begin
                    n_state = S_FIN;
                end else if (i_sts.dt_pos) begin
                    n_state = S_VDIV;
                end else begin
                    n_state = S_ACC;
                end
            end
            S_VDIV: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_VWAIT;
            end
            S_VWAIT: begin
                if (i_sts.div_done) begin
                    n_state = S_ACC;
                end
            end
            S_ACC: begin
                o_cmd.acc = 1'b1;
                n_state   = S_MDIV;
            end
            S_MDIV: begin
                o_cmd.mean_start = 1'b1;
                n_state          = S_MWAIT;
            end
            S_MWAIT: begin
                if (i_sts.div_done) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_out_valid;

endmodule

@@ rtl/windowed_track_velocity_estimator_top.sv @@
// Top level of the windowed track velocity estimator.
`timescale 1ns / 1ps

// Usage:
// Input channel (i_valid/o_ready) carries one timestamped position beat per
// sample; output channel (o_valid/i_ready) returns one result beat per sample
// with the window displacement, the mean interval velocity, the interval
// count and a flag for non-positive intervals.
// The configuration channel (i_cfg_valid/o_cfg_ready/i_cfg_data) writes the
// window size and empties the window; write it only while the block is idle.
// One sample is in flight at a time. With a positive interval the sample
// passes the sequencing steps, then waits on the serial velocity divider and
// then on the serial mean divider, each after its start step. The input is
// taken again in the cycle after the result is loaded; the dividers take up
// most of the time a sample occupies.
// Samples that leave fewer than two in the window skip the dividers, and an
// interval without positive duration skips the velocity division.
// The result sits in an output register, so the next sample is taken while
// a finished result waits; if the receiver stalls the following result, the
// block holds in its final step until the register frees up.
// Reset empties the window and sets the window size to eight.

module windowed_track_velocity_estimator_top #(
    parameter int MAX_WINDOW = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic signed [wtve_pkg::POS_W-1:0]   i_pos_x,
    input  logic signed [wtve_pkg::POS_W-1:0]   i_pos_y,
    input  logic [wtve_pkg::SEC_W-1:0]          i_time_sec,
    input  logic [wtve_pkg::USEC_W-1:0]         i_time_usec,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [wtve_pkg::SHF_W-1:0]   o_shift_x,
    output logic signed [wtve_pkg::SHF_W-1:0]   o_shift_y,
    output logic signed [wtve_pkg::VEL_W-1:0]   o_vel_x,
    output logic signed [wtve_pkg::VEL_W-1:0]   o_vel_y,
    output logic [wtve_pkg::ICNT_W-1:0]         o_interval_count,
    output logic                                o_bad_interval,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [wtve_pkg::CFG_W-1:0]          i_cfg_data
);

    import wtve_pkg::*;

    t_cmd cmd;
    t_sts sts;
    logic cfg_we;

    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid & o_cfg_ready;

    wtve_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_cmd   (cmd),
        .i_sts   (sts)
    );

    wtve_dp #(.MAX_WINDOW(MAX_WINDOW)) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_cfg_we         (cfg_we),
        .i_cfg_data       (i_cfg_data),
        .i_pos_x          (i_pos_x),
        .i_pos_y          (i_pos_y),
        .i_time_sec       (i_time_sec),
        .i_time_usec      (i_time_usec),
        .o_shift_x        (o_shift_x),
        .o_shift_y        (o_shift_y),
        .o_vel_x          (o_vel_x),
        .o_vel_y          (o_vel_y),
        .o_interval_count (o_interval_count),
        .o_bad_interval   (o_bad_interval)
    );

endmodule

@@ rtl/wtve_checker.sv @@
// Port level checks for the windowed track velocity estimator, bound to the top.
`timescale 1ns / 1ps

module wtve_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_valid,
    input logic                               o_ready,
    input logic                               o_valid,
    input logic                               i_ready,
    input logic signed [wtve_pkg::SHF_W-1:0]  o_shift_x,
    input logic signed [wtve_pkg::VEL_W-1:0]  o_vel_x
);

    // A stalled result beat keeps its x displacement and x velocity.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_shift_x) && $stable(o_vel_x)))
        else $error("result beat changed while stalled");

    // Only one sample is worked on at a time.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("input taken while a sample is in work");

    // Finishing a sample always leaves a result beat behind.
    a_done_has_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_ready) |-> o_valid)
        else $error("sample finished without a result beat");

    // A sample in work cannot produce a result in the cycle after it is taken.
    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && !o_valid) |=> !o_valid)
        else $error("result appeared too early");

endmodule

bind windowed_track_velocity_estimator_top wtve_checker u_wtve_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (i_valid),
    .o_ready     (o_ready),
    .o_valid     (o_valid),
    .i_ready     (i_ready),
    .o_shift_x   (o_shift_x),
    .o_vel_x     (o_vel_x)
);
